// ----- src/iuw_pkg.sv -----
`timescale 1ns / 1ps

package iuw_pkg;

    // Default sizing for the top level parameters
    localparam int DEF_MAX_WIDTH    = 512;
    localparam int DEF_MAX_HEIGHT   = 1024;
    localparam int DEF_MAX_SCALE    = 8;
    localparam int DEF_STRIDE_ALIGN = 64;

    // Register widths and reset values
    localparam int CFG_WIDTH_W  = 10;
    localparam int CFG_HEIGHT_W = 11;
    localparam int CFG_SCALE_W  = 4;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH  = CFG_WIDTH_W'(224);
    localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = CFG_HEIGHT_W'(288);
    localparam logic [CFG_SCALE_W-1:0]  RST_SCALE  = CFG_SCALE_W'(2);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] IDX_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_SCALE_FACTOR  = 2'd2;

    // Payload widths
    localparam int PIX_W     = 8;
    localparam int OFS_W     = 19;
    localparam int RUN_LEN_W = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP,
        ST_STRIDE,
        ST_BASE,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture pixel, counters and sizes
        logic recip;    // quotient estimate for the stride
        logic stride;   // corrected stride
        logic base;     // first run offset
        logic advance;  // one run transaction taken
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_run;
    } t_status;

endpackage

// ----- src/iuw_ctrl.sv -----
`timescale 1ns / 1ps

module iuw_ctrl
    import iuw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_pix_valid,
    output logic    o_pix_stall,
    output logic    o_run_valid,
    input  logic    i_run_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pix_valid) begin
                    n_state = ST_RECIP;
                end
            end
            ST_RECIP:  n_state = ST_STRIDE;
            ST_STRIDE: n_state = ST_BASE;
            ST_BASE:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (!i_run_stall && i_status.last_run) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_cmd       = '0;
        o_pix_stall = 1'b1;
        o_run_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pix_stall = 1'b0;
                o_cmd.load  = i_pix_valid;
            end
            ST_RECIP:  o_cmd.recip  = 1'b1;
            ST_STRIDE: o_cmd.stride = 1'b1;
            ST_BASE:   o_cmd.base   = 1'b1;
            ST_EMIT: begin
                o_run_valid   = 1'b1;
                o_cmd.advance = !i_run_stall;
            end
            default: ;
        endcase
    end

endmodule

// ----- src/iuw_datapath.sv -----
`timescale 1ns / 1ps

module iuw_datapath
    import iuw_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_SCALE    = DEF_MAX_SCALE,
    parameter int STRIDE_ALIGN = DEF_STRIDE_ALIGN
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [CFG_WIDTH_W-1:0]  i_cfg_width,
    input  logic [CFG_HEIGHT_W-1:0] i_cfg_height,
    input  logic [CFG_SCALE_W-1:0]  i_cfg_scale,
    input  logic [PIX_W-1:0]        i_pixel_value,
    output logic                    o_buffer_select,
    output logic [OFS_W-1:0]        o_dest_offset,
    output logic [PIX_W-1:0]        o_run_value,
    output logic [RUN_LEN_W-1:0]    o_run_length,
    output logic                    o_last_of_input,
    output logic                    o_frame_done
);

    localparam int COL_W  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int N_W    = $clog2(MAX_SCALE + 1);
    // scaled width plus rounding term stays below 2**SW_W
    localparam int SW_W   = $clog2(MAX_WIDTH * MAX_SCALE + STRIDE_ALIGN);
    localparam int PROD_W = 2 * SW_W + 1;
    // reciprocal of the alignment, estimate is exact or one low
    localparam longint RCP = (longint'(1) << SW_W) / STRIDE_ALIGN;

    logic [W_W-1:0] w_eff;
    logic [H_W-1:0] h_eff;
    logic [N_W-1:0] n_eff;
    logic           row_end;
    logic           frame_end;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              r_back;

    logic [PIX_W-1:0]  r_pix;
    logic              r_buf;
    logic              r_frame_end;
    logic [N_W-1:0]    r_n;
    logic [N_W-1:0]    r_run;
    logic [SW_W-1:0]   r_sw;
    logic [OFS_W-1:0]  r_colx;
    logic [OFS_W-1:0]  r_rown;
    logic [SW_W-1:0]   r_qe;
    logic [SW_W-1:0]   r_stride;
    logic [OFS_W-1:0]  r_ofs;

    logic [PROD_W-1:0] recip_prod;
    logic [SW_W-1:0]   stride_lo;
    logic [SW_W-1:0]   stride_rem;

    // Effective sizes: zero reads as one, large values saturate
    always_comb begin
        if (i_cfg_width == '0) begin
            w_eff = W_W'(1);
        end else if (int'(i_cfg_width) > MAX_WIDTH) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(i_cfg_width);
        end
        if (i_cfg_height == '0) begin
            h_eff = H_W'(1);
        end else if (int'(i_cfg_height) > MAX_HEIGHT) begin
            h_eff = H_W'(MAX_HEIGHT);
        end else begin
            h_eff = H_W'(i_cfg_height);
        end
        if (i_cfg_scale == '0) begin
            n_eff = N_W'(1);
        end else if (int'(i_cfg_scale) > MAX_SCALE) begin
            n_eff = N_W'(MAX_SCALE);
        end else begin
            n_eff = N_W'(i_cfg_scale);
        end
    end

    // A counter at or past the last position (size minus one) counts as the end of its row or frame
    assign row_end   = (int'(r_col) + 1) >= int'(w_eff);
    assign frame_end = row_end && ((int'(r_row) + 1) >= int'(h_eff));

    // Raster position and back buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_back <= 1'b1;
        end else if (i_cmd.load) begin
            if (row_end) begin
                r_col <= '0;
                if (frame_end) begin
                    r_row  <= '0;
                    r_back <= ~r_back;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Stride: round scaled width up to the alignment by reciprocal and fix-up
    assign recip_prod = PROD_W'(r_sw) * PROD_W'(RCP);
    assign stride_lo  = SW_W'(r_qe) * SW_W'(STRIDE_ALIGN);
    assign stride_rem = r_sw - stride_lo;

    // Item capture and offset arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix       <= i_pixel_value;
            r_buf       <= r_back;
            r_frame_end <= frame_end;
            r_n         <= n_eff;
            r_sw        <= SW_W'(w_eff) * SW_W'(n_eff) + SW_W'(STRIDE_ALIGN - 1);
            r_colx      <= OFS_W'(r_col) * OFS_W'(n_eff);
            r_rown      <= OFS_W'(r_row) * OFS_W'(n_eff);
        end
        if (i_cmd.recip) begin
            r_qe <= SW_W'(recip_prod >> SW_W);
        end
        if (i_cmd.stride) begin
            if (stride_rem >= SW_W'(STRIDE_ALIGN)) begin
                r_stride <= stride_lo + SW_W'(STRIDE_ALIGN);
            end else begin
                r_stride <= stride_lo;
            end
        end
        if (i_cmd.base) begin
            r_ofs <= OFS_W'(r_rown) * OFS_W'(r_stride) + r_colx;
        end else if (i_cmd.advance) begin
            r_ofs <= r_ofs + OFS_W'(r_stride);
        end
    end

    // Run index within the current pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_cmd.load) begin
            r_run <= '0;
        end else if (i_cmd.advance) begin
            r_run <= r_run + N_W'(1);
        end
    end

    assign o_status.last_run = (r_run + N_W'(1)) == r_n;

    assign o_buffer_select = r_buf;
    assign o_dest_offset   = r_ofs;
    assign o_run_value     = r_pix;
    assign o_run_length    = RUN_LEN_W'(r_n);
    assign o_last_of_input = o_status.last_run;
    assign o_frame_done    = o_status.last_run && r_frame_end;

endmodule

// ----- src/integer_pixel_upscale_writer_unit.sv -----
`timescale 1ns / 1ps

// Integer nearest-neighbor upscale writer.
// Input channel: one 8-bit source pixel per transaction, raster order, on
// i_pix_valid / o_pix_stall. Output channel: one horizontal run per
// transaction on o_run_valid / i_run_stall, carrying buffer select, byte
// offset, pixel value, run length, and last-of-pixel / end-of-frame flags.
// Each pixel gives scale runs, one per replicated destination row, top first.
// The first run of a pixel is valid once the controller has passed through
// ST_RECIP, ST_STRIDE and ST_BASE after its acceptance. In those states the
// stride reciprocal, its correction and the base offset multiply are done in
// turn, then the run offset steps by the stride once per run taken.
// The block handles one pixel at a time: o_pix_stall stays high from
// acceptance until the last run is taken. While i_run_stall is high the
// current run holds on the outputs. Reset clears the raster counters, sets
// the back buffer to one and loads width 224, height 288, scale 2. Registers
// are written through i_cfg_we, i_cfg_index and i_cfg_data; the user must
// write them only while the block is idle, and the block does not enforce
// it. The back buffer toggles after the last pixel of each frame.
module integer_pixel_upscale_writer_unit
    import iuw_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_SCALE    = DEF_MAX_SCALE,
    parameter int STRIDE_ALIGN = DEF_STRIDE_ALIGN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_pix_valid,
    output logic                  o_pix_stall,
    input  logic [PIX_W-1:0]      i_pixel_value,
    output logic                  o_run_valid,
    input  logic                  i_run_stall,
    output logic                  o_buffer_select,
    output logic [OFS_W-1:0]      o_dest_offset,
    output logic [PIX_W-1:0]      o_run_value,
    output logic [RUN_LEN_W-1:0]  o_run_length,
    output logic                  o_last_of_input,
    output logic                  o_frame_done
);

    logic [CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [CFG_HEIGHT_W-1:0] r_cfg_height;
    logic [CFG_SCALE_W-1:0]  r_cfg_scale;

    t_cmd    cmd;
    t_status status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_scale  <= RST_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                IDX_SOURCE_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                IDX_SOURCE_HEIGHT: r_cfg_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                IDX_SCALE_FACTOR:  r_cfg_scale  <= i_cfg_data[CFG_SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    iuw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_stall (o_pix_stall),
        .o_run_valid (o_run_valid),
        .i_run_stall (i_run_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    iuw_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_SCALE    (MAX_SCALE),
        .STRIDE_ALIGN (STRIDE_ALIGN)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_width     (r_cfg_width),
        .i_cfg_height    (r_cfg_height),
        .i_cfg_scale     (r_cfg_scale),
        .i_pixel_value   (i_pixel_value),
        .o_buffer_select (o_buffer_select),
        .o_dest_offset   (o_dest_offset),
        .o_run_value     (o_run_value),
        .o_run_length    (o_run_length),
        .o_last_of_input (o_last_of_input),
        .o_frame_done    (o_frame_done)
    );

endmodule
